@@ hdl/kbt_pkg.sv @@
// Package for the k-mer bucket table engine: sizes, op, status and register codes, command and status structs.
// No dependencies.
package kbt_pkg;
  localparam int PREFIX_BITS_DEF = 12;
  localparam int TABLE_DEPTH_DEF = 131072;
  localparam int VALUE_BITS_DEF  = 16;

  localparam logic [1:0] OP_COUNT  = 2'd0;
  localparam logic [1:0] OP_FINAL  = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_LOW      = 3'd1;
  localparam logic [2:0] ST_HIGH     = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [1:0] REG_MIN  = 2'd0;
  localparam logic [1:0] REG_MAX  = 2'd1;
  localparam logic [1:0] REG_KBIT = 2'd2;

  localparam int LEN_W    = 17;
  localparam int GAP      = 256;
  localparam int SCAN_LIM = 8;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input word, start bucket reads
    logic clr_step;  // finalize: write start/fill of walk index, advance
    logic cnt_wr;    // count write-back
    logic ins_wr;    // insert write-back
    logic lk_init;   // set search bounds
    logic lk_rd;     // issue store read at probe
    logic lk_eval;   // evaluate store read
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic walk_last;
    logic lk_bin;     // still in binary phase
    logic lk_more;    // scan has entries left
    logic lk_found;
    logic clr_busy;   // bucket tables being zeroed after reset
  } sts_t;
endpackage

@@ hdl/kbt_ctrl.sv @@
// Sequencer for count, finalize, insert and lookup.
// Depends on kbt_pkg.
module kbt_ctrl import kbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] op_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       res_set_o,
  input  logic       out_busy_i
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_EXEC = 3'd2, S_WALK = 3'd3,
                         S_LKRD = 3'd4, S_LKEV = 3'd5, S_DONE = 3'd6;
  logic [2:0] state_q, state_d;
  logic [1:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_COUNT;
    end else begin
      state_q <= state_d;
      if (in_valid && !in_stall) op_q <= op_i;
    end
  end

  assign in_stall = (state_q != S_IDLE) || out_busy_i || sts_i.clr_busy;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    res_set_o = 1'b0;
    case (state_q)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd_o.load = 1'b1;
        state_d = (op_i == OP_FINAL) ? S_WALK : S_RD;
      end
      S_RD: state_d = S_EXEC;
      S_EXEC: begin
        case (op_q)
          OP_COUNT: begin cmd_o.cnt_wr = 1'b1; state_d = S_DONE; end
          OP_INSERT: begin cmd_o.ins_wr = 1'b1; state_d = S_DONE; end
          default: begin cmd_o.lk_init = 1'b1; state_d = S_LKRD; end
        endcase
      end
      S_WALK: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.walk_last) state_d = S_DONE;
      end
      S_LKRD: begin
        if (sts_i.lk_found || (!sts_i.lk_bin && !sts_i.lk_more)) state_d = S_DONE;
        else begin cmd_o.lk_rd = 1'b1; state_d = S_LKEV; end
      end
      S_LKEV: begin cmd_o.lk_eval = 1'b1; state_d = S_LKRD; end
      S_DONE: begin
        res_set_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

@@ hdl/kbt_dpath.sv @@
// Bucket tables, entry stores, filter, prefix-sum walk and search bounds.
// Depends on kbt_pkg.
module kbt_dpath import kbt_pkg::*; #(
  parameter int PREFIX_BITS = PREFIX_BITS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [63:0] kmer_i,
  input  logic [15:0] value_i,
  input  logic [1:0]  op_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [16:0] index_o
);
  localparam int NB = 1 << PREFIX_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  // positions hold a full running sum of saturated lengths plus gaps
  localparam int PW_SUM = LEN_W + PREFIX_BITS + 1;
  localparam int PW = (PW_SUM > AW + 2) ? PW_SUM : AW + 2;
  localparam logic [PREFIX_BITS-1:0] AMASK = PREFIX_BITS'((NB - 1) >> 6);
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // configuration
  logic [15:0] min_q, max_q;
  logic [6:0]  kb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= 16'd1; max_q <= 16'hFFFF; kb_q <= 7'd42;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MIN: min_q <= cfg_data_i;
        REG_MAX: max_q <= cfg_data_i;
        REG_KBIT: kb_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // input split
  logic [6:0] kb_c, sw;
  logic [63:0] kshift, smask;
  logic [PREFIX_BITS-1:0] pre_c;
  always_comb begin
    kb_c = (kb_q > 7'd64) ? 7'd64 : kb_q;
    if (kb_c < 7'(PREFIX_BITS)) kb_c = 7'(PREFIX_BITS);
    sw = kb_c - 7'(PREFIX_BITS);
    kshift = kmer_i >> sw;
    pre_c = kshift[PREFIX_BITS-1:0];
    smask = (sw == 7'd64) ? '1 : ((64'd1 << sw) - 64'd1);
  end

  logic [63:0] suf_q;
  logic [15:0] v_q;
  logic [PREFIX_BITS-1:0] pre_q, wi_q;
  logic [15:0] lo16;
  logic [2:0]  filt_q;
  assign lo16 = (min_q == 16'd0) ? 16'd1 : min_q;

  // bucket memories
  logic [LEN_W-1:0] len_mem [NB];
  logic [PW-1:0]    start_mem [NB];
  logic [LEN_W-1:0] fill_mem [NB];
  logic [LEN_W-1:0] len_rd, fill_rd;
  logic [PW-1:0]    start_rd;
  logic [PREFIX_BITS-1:0] raddr;
  logic [LEN_W-1:0] len_cur, fill_cur;
  logic [PW-1:0]    pos_q, pos_nx;
  logic [PW:0]      end_q;
  logic             walk_rd_q;
  logic [PW-1:0]    loc;
  logic             ins_ok;
  logic             clr_busy_q;
  logic [PREFIX_BITS-1:0] clr_idx_q;
  logic                   len_we, fill_we;
  logic [PREFIX_BITS-1:0] len_wa, fill_wa;
  logic [LEN_W-1:0]       len_wd, fill_wd;

  // walk reads one bucket ahead so each step sees its own length
  assign raddr = cmd_i.load ? pre_c :
                 cmd_i.clr_step ? (walk_rd_q ? wi_q + 1'b1 : wi_q) : pre_q;

  // clearing pass after reset: zero one length/fill entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1; clr_idx_q <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == PREFIX_BITS'(NB - 1)) clr_busy_q <= 1'b0;
    end
  end
  assign sts_o.clr_busy = clr_busy_q;

  // table write ports
  always_comb begin
    len_we = 1'b1; len_wa = clr_idx_q; len_wd = '0;
    fill_we = 1'b1; fill_wa = clr_idx_q; fill_wd = '0;
    if (!clr_busy_q) begin
      len_we = cmd_i.cnt_wr && filt_q == ST_OK && len_cur < LEN_MAX;
      len_wa = pre_q;
      len_wd = len_cur + 1'b1;
      fill_we = 1'b0;
      if (cmd_i.clr_step) begin
        fill_we = 1'b1; fill_wa = wi_q;
      end else if (cmd_i.ins_wr && ins_ok) begin
        fill_we = 1'b1; fill_wa = pre_q; fill_wd = fill_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_rd <= len_mem[raddr];
    fill_rd <= fill_mem[raddr];
    start_rd <= start_mem[raddr];
    if (len_we) len_mem[len_wa] <= len_wd;
    if (fill_we) fill_mem[fill_wa] <= fill_wd;
    if (cmd_i.clr_step) start_mem[wi_q] <= pos_q;
  end

  assign len_cur  = len_rd;
  assign fill_cur = fill_rd;

  // entry stores
  logic [51:0] suf_mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] val_mem [TABLE_DEPTH];
  logic [51:0] tag_rd;
  logic [15:0] stored;
  assign loc = start_rd + PW'(fill_cur);
  assign ins_ok = (filt_q == ST_OK) && (fill_cur < len_cur) && (loc < PW'(TABLE_DEPTH));
  assign stored = v_q - (lo16 - 16'd1);

  logic [PW-1:0] lo_q, hi_q, probe;
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr && ins_ok) begin
      suf_mem[loc[AW-1:0]] <= suf_q[51:0];
      val_mem[loc[AW-1:0]] <= VALUE_BITS'(stored);
    end
    if (cmd_i.lk_rd) tag_rd <= suf_mem[probe[AW-1:0]];
  end

  // input capture and filter
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      suf_q <= kmer_i & smask;
      v_q <= value_i;
      pre_q <= pre_c;
      filt_q <= (value_i < lo16) ? ST_LOW : (value_i > max_q) ? ST_HIGH : ST_OK;
    end
  end

  // finalize walk
  assign pos_nx = pos_q + PW'(len_cur);
  assign sts_o.walk_last = walk_rd_q && (wi_q == PREFIX_BITS'(NB - 1));
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q <= '0; pos_q <= '0; walk_rd_q <= 1'b0; end_q <= '0;
    end else if (cmd_i.load) begin
      wi_q <= '0; pos_q <= '0; walk_rd_q <= 1'b0; end_q <= '0;
    end else if (cmd_i.clr_step) begin
      // first cycle primes the read of bucket 0
      if (!walk_rd_q) walk_rd_q <= 1'b1;
      else begin
        end_q <= (PW+1)'(pos_nx);
        pos_q <= pos_nx + (((wi_q & AMASK) == AMASK) ? PW'(GAP) : '0);
        wi_q <= wi_q + 1'b1;
      end
    end
  end

  // lookup bounds
  logic bin_ph_q, found_q, probe_scan;
  logic [PW-1:0] mid;
  logic [PW:0] hsum;
  assign mid = lo_q + ((hi_q - lo_q) >> 1);
  assign probe = bin_ph_q ? mid : lo_q;
  assign sts_o.lk_bin = bin_ph_q;
  assign sts_o.lk_more = lo_q < hi_q;
  assign sts_o.lk_found = found_q;
  assign hsum = (PW+1)'(start_rd) + (PW+1)'(fill_cur);
  assign probe_scan = !bin_ph_q;
  logic [PW-1:0] hi_c, lo_c, idx_q;
  always_comb begin
    hi_c = (hsum > (PW+1)'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : hsum[PW-1:0];
    lo_c = (start_rd > hi_c) ? hi_c : start_rd;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      found_q <= 1'b0; idx_q <= '0;
    end else if (cmd_i.lk_init) begin
      lo_q <= lo_c; hi_q <= hi_c;
      bin_ph_q <= (lo_c + PW'(SCAN_LIM)) < hi_c;
    end else if (cmd_i.lk_eval) begin
      if (tag_rd == suf_q[51:0]) begin
        found_q <= 1'b1; idx_q <= probe;
      end else if (probe_scan) lo_q <= lo_q + 1'b1;
      else begin
        if (suf_q[51:0] < tag_rd) begin
          hi_q <= mid;
          bin_ph_q <= (lo_q + PW'(SCAN_LIM)) < mid;
        end else begin
          lo_q <= mid + 1'b1;
          bin_ph_q <= (mid + 1'b1 + PW'(SCAN_LIM)) < hi_q;
        end
      end
    end else if (cmd_i.ins_wr && ins_ok) idx_q <= loc;
  end

  // insert outcome
  logic [1:0] ins_rs_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_wr)
      ins_rs_q <= (fill_cur >= len_cur) ? 2'd1 : (loc >= PW'(TABLE_DEPTH)) ? 2'd2 : 2'd0;
  end

  // result word
  always_comb begin
    status_o = ST_OK; found_o = 1'b0; index_o = '0;
    case (op_i)
      OP_COUNT: status_o = filt_q;
      OP_FINAL: status_o = (end_q > (PW+1)'(TABLE_DEPTH)) ? ST_FULL : ST_OK;
      OP_INSERT: begin
        status_o = filt_q;
        if (filt_q == ST_OK) begin
          if (ins_rs_q == 2'd1) status_o = ST_OVERFLOW;
          else if (ins_rs_q == 2'd2) status_o = ST_FULL;
          else index_o = 17'(idx_q);
        end
      end
      default: begin found_o = found_q; index_o = found_q ? 17'(idx_q) : '0; end
    endcase
  end
endmodule

@@ hdl/kmer_bucket_table_engine_core.sv @@
// Top level of the k-mer bucket table engine: controller, datapath, output register.
// Depends on kbt_pkg, kbt_ctrl, kbt_dpath.
//
//  channel  | handshake          | contents
//  in       | in_valid/in_stall  | op_i, kmer_i, count_value_i
//  out      | out_valid/out_stall| status_o, found_o, entry_index_o
//  cfg      | cfg_valid/cfg_ready| cfg_index_i, cfg_data_i
//
// Count and insert go through a bucket read, a write-back and the result.
// Finalize walks the length memory one bucket a cycle, 2^PREFIX_BITS buckets in all.
// Lookup makes about log2 of the bucket in binary store reads plus up to 8 scan reads.
// Reset clears the controller, then a clearing pass zeroes all 2^PREFIX_BITS entries of
// the length and fill tables; the input stalls until it ends.
// The input stalls while a word is in flight and while a result waits stalled.
module kmer_bucket_table_engine_core import kbt_pkg::*; #(
  parameter int PREFIX_BITS = PREFIX_BITS_DEF,
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op_i,
  input  logic [63:0] kmer_i,
  input  logic [15:0] count_value_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_o,
  output logic        found_o,
  output logic [16:0] entry_index_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;
  logic res_set;
  logic [1:0] op_q;
  logic [2:0] st_w;
  logic fd_w;
  logic [16:0] ix_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) op_q <= OP_COUNT;
    else if (cmd.load) op_q <= op_i;
  end

  kbt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i,
    .sts_i(sts), .cmd_o(cmd), .res_set_o(res_set),
    .out_busy_i(out_valid && out_stall)
  );

  kbt_dpath #(.PREFIX_BITS(PREFIX_BITS), .TABLE_DEPTH(TABLE_DEPTH),
              .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_valid && cfg_ready), .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .kmer_i, .value_i(count_value_i), .op_i(op_q),
    .cmd_i(cmd), .sts_o(sts),
    .status_o(st_w), .found_o(fd_w), .index_o(ix_w)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid <= 1'b0;
    else if (res_set) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (res_set) begin
      status_o <= st_w; found_o <= fd_w; entry_index_o <= ix_w;
    end
  end
endmodule
